>>> hdl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and constants for the circular FIFO with search
// Holds the queue depth, field widths, command and status codes, the
// controller states and the control bundle that drives each storage cell.
// ----------------------------------------------------------------------------
package cfs_pkg;

  // Queue geometry.
  localparam int DEPTH  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int SLOT_W = 3;

  typedef logic signed [WORD_W-1:0] word_t;

  // Command codes carried by one input transaction.
  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  // Status codes carried by one result transaction.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    FSM_IDLE,
    FSM_SEARCH
  } fsm_state_t;

  // Per-cell control: load a new word, or take the neighbor's word.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> hdl/circular_fifo_with_search.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_search: ring queue of signed words with a key search
// Top level. Each input transaction carries one command and yields exactly
// one result transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries in_opcode, in_push_value and in_search_key;
//   the result channel carries out_status, out_popped_value, out_found_slot.
//   A transaction moves on a rising edge with valid high and stall low.
//   For enqueue, dequeue and the unused code the result is registered and
//   visible the cycle after acceptance, and a new command can be taken
//   every cycle while results are drained.
//   Search holds the input until its result is registered: the words sit
//   in a chain of cells, oldest in front, and the chain rotates one cell
//   per cycle past a single comparator at the front until it is back in
//   place. The input is stalled meanwhile. A search on an empty queue does
//   not rotate the chain; its result is registered like a dequeue's.
//   Reset empties the queue and drops any pending result; stored words are
//   not cleared. While a result waits under out_stall, in_stall is raised,
//   so no command is taken until the result is consumed.
// ----------------------------------------------------------------------------
module circular_fifo_with_search (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic signed [cfs_pkg::WORD_W-1:0] in_push_value,
  input  logic signed [cfs_pkg::WORD_W-1:0] in_search_key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic signed [cfs_pkg::WORD_W-1:0] out_popped_value,
  output logic [cfs_pkg::SLOT_W-1:0]     out_found_slot
);
  import cfs_pkg::*;

  // Low SLOT_W bits of a physical slot index, zero-extended if narrower.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  // Next physical index around the ring.
  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  fsm_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;

  logic [IDX_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  word_t            key_r, key_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  word_t                 out_popped_r, out_popped_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;

  logic       accept_in;
  opcode_t    op;
  logic       queue_full;
  logic       queue_empty;
  logic       enq_ok;
  logic       deq_ok;
  logic       search_go;
  logic       rotate;
  logic       last_step;
  logic       hit_now;

  word_t      cell_data [DEPTH];
  cell_ctrl_t cell_ctrl [DEPTH];

  // Command decode at the input handshake.
  assign accept_in   = in_valid && !in_stall;
  assign op          = opcode_t'(in_opcode);
  assign queue_full  = (count_r == CNT_W'(DEPTH));
  assign queue_empty = (count_r == '0);
  assign enq_ok      = accept_in && (op == OP_ENQ) && !queue_full;
  assign deq_ok      = accept_in && (op == OP_DEQ) && !queue_empty;
  assign search_go   = accept_in && (op == OP_SEARCH) && !queue_empty;

  // Front-cell comparison during a search; only live entries can match.
  assign last_step = rotate && (step_r == IDX_W'(DEPTH - 1));
  assign hit_now   = rotate && (CNT_W'(step_r) < count_r) && (cell_data[0] == key_r);

  // Chain of cells: cell k holds the k-th oldest word and takes the word of
  // cell k+1 on a shift; the last cell wraps to the front for rotation.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign cell_ctrl[k].load  = enq_ok && (count_r == CNT_W'(k));
    assign cell_ctrl[k].shift = deq_ok || rotate;

    cfs_cell u_cell (
      .clk           (clk),
      .ctrl          (cell_ctrl[k]),
      .neighbor_data (cell_data[(k + 1) % DEPTH]),
      .push_data     (in_push_value),
      .data          (cell_data[k])
    );
  end

  // Controller next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (search_go) begin
          state_nxt = FSM_SEARCH;
        end
      end
      FSM_SEARCH: begin
        if (last_step) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall = 1'b0;
    rotate   = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_stall = out_valid_r && out_stall;
      end
      FSM_SEARCH: begin
        in_stall = 1'b1;
        rotate   = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Occupancy and physical head of the ring.
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    if (enq_ok) begin
      count_nxt = count_r + 1'b1;
      if (queue_empty) begin
        head_nxt = '0;
      end
    end else if (deq_ok) begin
      count_nxt = count_r - 1'b1;
      if (count_r == CNT_W'(1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = ring_inc(head_r);
      end
    end
  end

  // Search walk: step count, physical slot at the front, first hit.
  always_comb begin
    step_nxt = step_r;
    ptr_nxt  = ptr_r;
    hit_nxt  = hit_r;
    slot_nxt = slot_r;
    key_nxt  = key_r;
    if (search_go) begin
      step_nxt = '0;
      ptr_nxt  = head_r;
      hit_nxt  = 1'b0;
      key_nxt  = in_search_key;
    end else if (rotate) begin
      step_nxt = step_r + 1'b1;
      ptr_nxt  = ring_inc(ptr_r);
      if (hit_now && !hit_r) begin
        hit_nxt  = 1'b1;
        slot_nxt = ptr_r;
      end
    end
  end

  // Result register: loaded on an accepted command that starts no search, or at the end of a search.
  always_comb begin
    out_status_nxt = out_status_r;
    out_popped_nxt = out_popped_r;
    out_slot_nxt   = out_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (last_step) begin
      out_valid_nxt  = 1'b1;
      out_popped_nxt = '0;
      if (hit_r) begin
        out_status_nxt = STAT_OK;
        out_slot_nxt   = to_slot(slot_r);
      end else if (hit_now) begin
        out_status_nxt = STAT_OK;
        out_slot_nxt   = to_slot(ptr_r);
      end else begin
        out_status_nxt = STAT_MISS;
        out_slot_nxt   = '0;
      end
    end else if (accept_in && !search_go) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STAT_OK;
      out_popped_nxt = '0;
      out_slot_nxt   = '0;
      case (op)
        OP_ENQ: begin
          if (queue_full) begin
            out_status_nxt = STAT_FULL;
          end
        end
        OP_DEQ: begin
          if (queue_empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            out_popped_nxt = cell_data[0];
          end
        end
        OP_SEARCH: begin
          out_status_nxt = STAT_EMPTY;
        end
        default: begin
          out_status_nxt = STAT_OK;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    ptr_r        <= ptr_nxt;
    hit_r        <= hit_nxt;
    slot_r       <= slot_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_popped_r <= out_popped_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_found_slot   = out_slot_r;

`ifndef NO_ASSERTIONS
  // Occupancy never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy exceeds depth");

  // An empty ring always has its head at slot zero.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0))
    else $error("empty queue with nonzero head");

  // A pending full report means the ring is still full.
  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_FULL) |-> (count_r == CNT_W'(DEPTH)))
    else $error("full status reported on a non-full queue");

  // The occupancy and head stay put while a search rotates the chain.
  a_search_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_SEARCH) |=> $stable(count_r) && $stable(head_r))
    else $error("queue changed during a search");
`endif

endmodule

>>> hdl/cfs_cell.sv
// ----------------------------------------------------------------------------
// cfs_cell: one storage cell of the queue chain
// Holds one word. It either captures a newly pushed word or takes the word
// of its upstream neighbor, so the chain shifts toward the front cell.
// ----------------------------------------------------------------------------
module cfs_cell (
  input  logic               clk,
  input  cfs_pkg::cell_ctrl_t ctrl,
  input  cfs_pkg::word_t     neighbor_data,
  input  cfs_pkg::word_t     push_data,
  output cfs_pkg::word_t     data
);
  import cfs_pkg::*;

  word_t data_r;

  // Load has priority; the two never occur together.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data_r <= push_data;
    end else if (ctrl.shift) begin
      data_r <= neighbor_data;
    end
  end

  assign data = data_r;

endmodule

>>> dv/circular_fifo_with_search_tb.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_search_tb: self-checking bench for the searchable ring
// Sends enqueue, dequeue, search and no-op commands over the input channel.
// A ring model in the bench predicts each result transaction. A monitor
// compares every accepted result with the oldest prediction. A directed
// pass covers the corner cases, and random traffic under three idling
// patterns follows.
// ----------------------------------------------------------------------------
module circular_fifo_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int DRAIN_CYCLES = DEPTH + 4;

  // One predicted or observed result transaction.
  typedef struct packed {
    status_t             status;
    word_t               popped;
    logic [SLOT_W-1:0]   slot;
  } fifo_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = OP_NOP;
  word_t                in_push_value = '0;
  word_t                in_search_key = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  word_t                out_popped_value;
  logic [SLOT_W-1:0]    out_found_slot;

  // Ring model state.
  word_t                ring_slot [DEPTH];
  int unsigned          ring_head;
  int unsigned          ring_tail;
  bit                   ring_empty;

  fifo_result_t         pending_results [$];
  fifo_result_t         want_result;

  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   error_count = 0;
  int                   cycle_count = 0;
  int                   op_count [4];
  int                   status_count [4];

  circular_fifo_with_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .in_search_key    (in_search_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_found_slot   (out_found_slot)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circular_fifo_with_search test failed");
      $finish;
    end
  end

  // Number of words currently held by the ring model.
  function automatic int unsigned ring_count();
    if (ring_empty) begin
      return 0;
    end
    return ((ring_tail + DEPTH - ring_head) % DEPTH) + 1;
  endfunction

  // Applies one command to the ring model and returns its result.
  function automatic fifo_result_t apply_command(opcode_t op, word_t push, word_t key);
    fifo_result_t res;
    int unsigned  pos;
    int unsigned  n;
    res = '{status: STAT_OK, popped: '0, slot: '0};
    case (op)
      OP_ENQ: begin
        if (!ring_empty && ((ring_tail + 1) % DEPTH) == ring_head) begin
          res.status = STAT_FULL;
        end else begin
          if (ring_empty) begin
            ring_head  = 0;
            ring_tail  = 0;
            ring_empty = 1'b0;
          end else begin
            ring_tail = (ring_tail + 1) % DEPTH;
          end
          ring_slot[ring_tail] = push;
        end
      end
      OP_DEQ: begin
        if (ring_empty) begin
          res.status = STAT_EMPTY;
        end else begin
          res.popped = ring_slot[ring_head];
          // Taking the last word empties the ring and rewinds both indexes.
          if (ring_head == ring_tail) begin
            ring_head  = 0;
            ring_tail  = 0;
            ring_empty = 1'b1;
          end else begin
            ring_head = (ring_head + 1) % DEPTH;
          end
        end
      end
      OP_SEARCH: begin
        if (ring_empty) begin
          res.status = STAT_EMPTY;
        end else begin
          n          = ring_count();
          pos        = ring_head;
          res.status = STAT_MISS;
          for (int unsigned k = 0; k < n; k++) begin
            if (ring_slot[pos] == key) begin
              res.status = STAT_OK;
              res.slot   = pos[SLOT_W-1:0];
              break;
            end
            pos = (pos + 1) % DEPTH;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Sends one command transaction, with random idle cycles before it.
  // It returns at the edge where the transaction was accepted.
  task automatic issue_command(opcode_t op, word_t push, word_t key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_push_value <= push;
    in_search_key <= key;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    pending_results.push_back(apply_command(op, push, key));
    op_count[op]++;
  endtask

  // Result monitor: random back-pressure and a field-by-field comparison.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d popped %0d slot %0d",
                 out_status, out_popped_value, out_found_slot);
          error_count++;
        end else begin
          want_result = pending_results.pop_front();
          status_count[want_result.status]++;
          if (out_status !== want_result.status) begin
            $error("status: expected %0d, actual %0d", want_result.status, out_status);
            error_count++;
          end
          if (out_popped_value !== want_result.popped) begin
            $error("popped_value: expected %0d, actual %0d",
                   want_result.popped, out_popped_value);
            error_count++;
          end
          if (out_found_slot !== want_result.slot) begin
            $error("found_slot: expected %0d, actual %0d", want_result.slot, out_found_slot);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Extremes, small repeated values and a mix of random words.
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      4, 5, 6: return word_t'($urandom_range(1, 6));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Commands on an empty queue, and the unused code.
  task automatic test_empty_queue();
    issue_command(OP_DEQ, 32'sd11, 32'sd0);
    issue_command(OP_SEARCH, 32'sd0, 32'sd0);
    issue_command(OP_NOP, -1, -1);
  endtask

  // Fill every slot, then try one more enqueue.
  task automatic test_fill_to_full();
    issue_command(OP_ENQ, 32'sh8000_0000, 32'sd0);
    issue_command(OP_ENQ, 32'sh7fff_ffff, 32'sd0);
    issue_command(OP_ENQ, 32'sd0, 32'sd0);
    issue_command(OP_ENQ, -1, 32'sd0);
    issue_command(OP_ENQ, 32'sd5, 32'sd0);
    issue_command(OP_ENQ, 32'sd5, 32'sd0);
    issue_command(OP_ENQ, 32'shaaaa_aaaa, 32'sd0);
    issue_command(OP_ENQ, 32'sh5555_5555, 32'sd0);
    issue_command(OP_ENQ, 32'sd99, 32'sd0);
  endtask

  // A duplicated key reports its oldest copy; an absent key misses.
  task automatic test_search_hits();
    issue_command(OP_SEARCH, 32'sd0, 32'sd5);
    issue_command(OP_SEARCH, 32'sd0, 32'sd123);
  endtask

  // Wrap the tail past the last slot, search there, then empty the queue.
  task automatic test_wrap_and_drain();
    repeat (3) issue_command(OP_DEQ, 32'sd0, 32'sd0);
    issue_command(OP_ENQ, 32'sd77, 32'sd0);
    issue_command(OP_SEARCH, 32'sd0, 32'sd77);
    repeat (6) issue_command(OP_DEQ, 32'sd0, 32'sd0);
  endtask

  // Random traffic that swings between filling and draining the queue.
  task automatic test_random_traffic(int items);
    opcode_t     op;
    word_t       key;
    int          fill_pct;
    int          roll;
    int unsigned n;
    fill_pct = 70;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) begin
        fill_pct = (fill_pct >= 50) ? 30 : 70;
        if ($urandom_range(0, 3) == 0) begin
          fill_pct = 50;
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        op = OP_NOP;
      end else if (roll < 34) begin
        op = OP_SEARCH;
      end else if ($urandom_range(0, 99) < fill_pct) begin
        op = OP_ENQ;
      end else begin
        op = OP_DEQ;
      end
      // Most searches look for a word that is in the queue.
      n = ring_count();
      if (n != 0 && $urandom_range(0, 99) < 60) begin
        key = ring_slot[(ring_head + $urandom_range(0, n - 1)) % DEPTH];
      end else begin
        key = pick_word();
      end
      issue_command(op, pick_word(), key);
    end
  endtask

  // Test sequence.
  initial begin
    ring_head     = 0;
    ring_tail     = 0;
    ring_empty    = 1'b1;
    send_idle_pct = 14;
    recv_idle_pct = 47;
    foreach (ring_slot[i]) ring_slot[i] = '0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_search_hits();
    test_wrap_and_drain();

    test_random_traffic(RANDOM_ITEMS / 3);
    send_idle_pct = 47;
    recv_idle_pct = 14;
    test_random_traffic(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Commands sent: %0d enqueue, %0d dequeue, %0d search, %0d no-op.",
             op_count[OP_ENQ], op_count[OP_DEQ], op_count[OP_SEARCH], op_count[OP_NOP]);
    $display("Results checked: %0d ok, %0d full, %0d empty, %0d not found.",
             status_count[STAT_OK], status_count[STAT_FULL],
             status_count[STAT_EMPTY], status_count[STAT_MISS]);
    if (error_count == 0) begin
      $display("circular_fifo_with_search test passed");
    end else begin
      $display("circular_fifo_with_search test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/cfs_pkg.sv
hdl/cfs_cell.sv
hdl/circular_fifo_with_search.sv
dv/circular_fifo_with_search_tb.sv
